// ===== sv/lbac_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package lbac_pkg;

    localparam int LBA_W      = 28;
    localparam int BYTE_W     = 8;
    localparam int HEAD_W     = 5;
    localparam int CYL_W      = 16;
    localparam int PORT_W     = 10;
    localparam int CFG_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 24;

    // The divider retires this many quotient bits in each cycle while it is busy.
    localparam int DIV_BITS   = 2;
    localparam int DIV_STEPS  = LBA_W / DIV_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [PORT_W-1:0] PORT_CONTROL = 10'h3F6;
    localparam logic [PORT_W-1:0] PORT_PRECOMP = 10'h1F1;
    localparam logic [PORT_W-1:0] PORT_COUNT   = 10'h1F2;
    localparam logic [PORT_W-1:0] PORT_SECTOR  = 10'h1F3;
    localparam logic [PORT_W-1:0] PORT_CYL_LO  = 10'h1F4;
    localparam logic [PORT_W-1:0] PORT_CYL_HI  = 10'h1F5;
    localparam logic [PORT_W-1:0] PORT_DRVHEAD = 10'h1F6;
    localparam logic [PORT_W-1:0] PORT_COMMAND = 10'h1F7;

    localparam logic [BYTE_W-1:0] DRVHEAD_BASE = 8'hA0;

    localparam logic [BYTE_W-1:0] CONTROL_RESET = 8'd0;
    localparam logic [BYTE_W-1:0] PRECOMP_RESET = 8'd0;
    localparam logic [BYTE_W-1:0] SPT_RESET     = 8'd17;
    localparam logic [HEAD_W-1:0] HEADS_RESET   = 5'd4;

    typedef enum logic [1:0] {
        CFG_CONTROL,
        CFG_PRECOMP,
        CFG_SPT,
        CFG_HEADS
    } cfg_idx_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_SECT,
        F_HEAD,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        W_CONTROL,
        W_PRECOMP,
        W_COUNT,
        W_SECTOR,
        W_CYL_LO,
        W_CYL_HI,
        W_DRVHEAD,
        W_COMMAND
    } word_sel_t;

    typedef struct packed {
        logic [BYTE_W-1:0] sector_count;
        logic [BYTE_W-1:0] sector;
        logic [CYL_W-1:0]  cylinder;
        logic [HEAD_W-1:0] head;
        logic [BYTE_W-1:0] command_code;
    } cmd_entry_t;

    typedef struct packed {
        logic              start;
        logic [LBA_W-1:0]  dividend;
        logic [BYTE_W-1:0] divisor;
    } div_req_t;

endpackage
`default_nettype wire

// ===== sv/lba_to_chs_command_issuer.sv =====
// Output: each request gives eight register writes, issued in order from the output
// register one per cycle while m_tready stays high.
// Divider: the shared 2-bit-per-cycle divider runs twice per request (address by
// sectors, track by heads) and so sets the request rate; one more word can wait meanwhile.
// Reset: aresetn is synchronous and active low; it empties the queue and output
// register and returns the geometry registers to 17 sectors and 4 heads.
`timescale 1ns / 1ps
`default_nettype none
module lba_to_chs_command_issuer
    import lbac_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // linear_sector [27:0], sector_count [35:28], command_code [43:36], zeros above
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // port_address [9:0], write_data [17:10], zeros above
    output logic [M_TDATA_W-1:0]       m_tdata,
    output logic                       m_tlast,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    logic [BYTE_W-1:0] control_byte_reg;
    logic [BYTE_W-1:0] precomp_byte_reg;
    logic [BYTE_W-1:0] spt_reg;
    logic [HEAD_W-1:0] heads_reg;

    logic              cfg_wr;
    cfg_idx_t          cfg_idx;

    logic              q_full;
    logic              q_push;
    logic              q_pop;
    logic              q_valid;
    cmd_entry_t        q_din;
    cmd_entry_t        q_dout;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = cfg_idx_t'(paddr[CFG_ADDR_W-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            control_byte_reg <= CONTROL_RESET;
            precomp_byte_reg <= PRECOMP_RESET;
            spt_reg          <= SPT_RESET;
            heads_reg        <= HEADS_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                CFG_CONTROL: control_byte_reg <= pwdata[BYTE_W-1:0];
                CFG_PRECOMP: precomp_byte_reg <= pwdata[BYTE_W-1:0];
                CFG_SPT:     spt_reg          <= pwdata[BYTE_W-1:0];
                CFG_HEADS:   heads_reg        <= pwdata[HEAD_W-1:0];
                default:     control_byte_reg <= control_byte_reg;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            CFG_CONTROL: prdata = APB_DATA_W'(control_byte_reg);
            CFG_PRECOMP: prdata = APB_DATA_W'(precomp_byte_reg);
            CFG_SPT:     prdata = APB_DATA_W'(spt_reg);
            CFG_HEADS:   prdata = APB_DATA_W'(heads_reg);
            default:     prdata = '0;
        endcase
    end

    lbac_front u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .sectors_per_track (spt_reg),
        .head_count        (heads_reg),
        .q_full            (q_full),
        .push              (q_push),
        .entry             (q_din)
    );

    lbac_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (q_din),
        .full    (q_full),
        .pop     (q_pop),
        .dout    (q_dout),
        .valid   (q_valid)
    );

    lbac_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_dout       (q_dout),
        .pop          (q_pop),
        .control_byte (control_byte_reg),
        .precomp_byte (precomp_byte_reg),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast)
    );

endmodule
`default_nettype wire

// ===== sv/lbac_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lbac_div
    import lbac_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire div_req_t          req,
    output logic                   done,
    output logic [LBA_W-1:0]       quotient,
    output logic [BYTE_W-1:0]      remainder
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [LBA_W-1:0]     quo_reg, quo_next;
    logic [BYTE_W-1:0]    rem_reg, rem_next;
    logic [BYTE_W-1:0]    dvs_reg, dvs_next;

    logic [LBA_W-1:0]     sq [DIV_BITS+1];
    logic [BYTE_W-1:0]    sr [DIV_BITS+1];
    logic [BYTE_W:0]      st [DIV_BITS];

    // Restoring division: the dividend shifts out at the top while quotient
    // bits shift in at the bottom of the same register.
    always_comb begin
        sq[0] = quo_reg;
        sr[0] = rem_reg;
        for (int i = 0; i < DIV_BITS; i++) begin
            st[i] = {sr[i], sq[i][LBA_W-1]};
            if (st[i] >= {1'b0, dvs_reg}) begin
                sr[i+1] = BYTE_W'(st[i] - {1'b0, dvs_reg});
                sq[i+1] = {sq[i][LBA_W-2:0], 1'b1};
            end else begin
                sr[i+1] = st[i][BYTE_W-1:0];
                sq[i+1] = {sq[i][LBA_W-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            quo_next = sq[DIV_BITS];
            rem_next = sr[DIV_BITS];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

// ===== sv/lbac_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lbac_front
    import lbac_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // linear_sector [27:0], sector_count [35:28], command_code [43:36], zeros above
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic [BYTE_W-1:0]    sectors_per_track,
    input  wire logic [HEAD_W-1:0]    head_count,
    input  wire logic                 q_full,
    output logic                      push,
    output cmd_entry_t                entry
);

    logic              in_valid_reg, in_valid_next;
    logic [LBA_W-1:0]  in_lba_reg;
    logic [BYTE_W-1:0] in_nsect_reg;
    logic [BYTE_W-1:0] in_cmd_reg;

    front_state_t      state_reg, state_next;
    cmd_entry_t        ent_reg, ent_next;

    logic              take;
    logic [BYTE_W-1:0] spt_eff;
    logic [HEAD_W-1:0] heads_eff;

    div_req_t          div_req;
    logic              div_done;
    logic [LBA_W-1:0]  div_quo;
    logic [BYTE_W-1:0] div_rem;

    lbac_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (div_req),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // A zero geometry value divides as one.
    assign spt_eff   = (sectors_per_track == '0) ? BYTE_W'(1) : sectors_per_track;
    assign heads_eff = (head_count == '0) ? HEAD_W'(1) : head_count;

    // The input register lets the next word land while the divider is busy.
    assign s_tready = !in_valid_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (take) begin
            in_valid_next = 1'b0;
        end
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: begin
                if (in_valid_reg) begin
                    state_next = F_SECT;
                end
            end
            F_SECT: begin
                if (div_done) begin
                    state_next = F_HEAD;
                end
            end
            F_HEAD: begin
                if (div_done) begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!q_full) begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = in_lba_reg;
        div_req.divisor  = spt_eff;
        take             = 1'b0;
        push             = 1'b0;
        ent_next         = ent_reg;
        case (state_reg)
            F_IDLE: begin
                if (in_valid_reg) begin
                    div_req.start         = 1'b1;
                    take                  = 1'b1;
                    ent_next.sector_count = in_nsect_reg;
                    ent_next.command_code = in_cmd_reg;
                end
            end
            F_SECT: begin
                if (div_done) begin
                    // The track number goes straight back in, divided by heads.
                    div_req.start    = 1'b1;
                    div_req.dividend = div_quo;
                    div_req.divisor  = BYTE_W'(heads_eff);
                    ent_next.sector  = div_rem + 1'b1;
                end
            end
            F_HEAD: begin
                if (div_done) begin
                    ent_next.cylinder = div_quo[CYL_W-1:0];
                    ent_next.head     = div_rem[HEAD_W-1:0];
                end
            end
            F_PUSH: begin
                push = !q_full;
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            state_reg    <= F_IDLE;
        end else begin
            in_valid_reg <= in_valid_next;
            state_reg    <= state_next;
        end
        if (s_tvalid && s_tready) begin
            in_lba_reg   <= s_tdata[LBA_W-1:0];
            in_nsect_reg <= s_tdata[LBA_W +: BYTE_W];
            in_cmd_reg   <= s_tdata[LBA_W+BYTE_W +: BYTE_W];
        end
        ent_reg <= ent_next;
    end

    assign entry = ent_reg;

endmodule
`default_nettype wire

// ===== sv/lbac_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lbac_queue
    import lbac_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push,
    input  wire cmd_entry_t din,
    output logic            full,
    input  wire logic       pop,
    output cmd_entry_t      dout,
    output logic            valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_entry_t       mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == CNT_W'(DEPTH));
    assign valid = (cnt_reg != '0);
    assign dout  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= din;
        end
    end

endmodule
`default_nettype wire

// ===== sv/lbac_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lbac_back
    import lbac_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 q_valid,
    input  wire cmd_entry_t           q_dout,
    output logic                      pop,
    input  wire logic [BYTE_W-1:0]    control_byte,
    input  wire logic [BYTE_W-1:0]    precomp_byte,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // port_address [9:0], write_data [17:10], zeros above
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic                      m_tlast
);

    localparam int PAD_W = M_TDATA_W - PORT_W - BYTE_W;

    logic              act_reg, act_next;
    cmd_entry_t        cur_reg, cur_next;
    word_sel_t         sel_reg, sel_next;
    logic              out_valid_reg, out_valid_next;
    logic [PORT_W-1:0] out_port_reg, out_port_next;
    logic [BYTE_W-1:0] out_data_reg, out_data_next;
    logic              out_last_reg, out_last_next;

    logic              load;
    logic              finish;
    logic [PORT_W-1:0] w_port;
    logic [BYTE_W-1:0] w_data;

    // While a run is active, a new word enters the output register whenever it is empty or being taken.
    assign load   = act_reg && (!out_valid_reg || m_tready);
    assign finish = load && (sel_reg == W_COMMAND);
    assign pop    = q_valid && (!act_reg || finish);

    always_comb begin
        case (sel_reg)
            W_CONTROL: begin
                w_port = PORT_CONTROL;
                w_data = control_byte;
            end
            W_PRECOMP: begin
                w_port = PORT_PRECOMP;
                w_data = precomp_byte;
            end
            W_COUNT: begin
                w_port = PORT_COUNT;
                w_data = cur_reg.sector_count;
            end
            W_SECTOR: begin
                w_port = PORT_SECTOR;
                w_data = cur_reg.sector;
            end
            W_CYL_LO: begin
                w_port = PORT_CYL_LO;
                w_data = cur_reg.cylinder[BYTE_W-1:0];
            end
            W_CYL_HI: begin
                w_port = PORT_CYL_HI;
                w_data = cur_reg.cylinder[CYL_W-1:BYTE_W];
            end
            W_DRVHEAD: begin
                w_port = PORT_DRVHEAD;
                w_data = DRVHEAD_BASE | BYTE_W'(cur_reg.head);
            end
            W_COMMAND: begin
                w_port = PORT_COMMAND;
                w_data = cur_reg.command_code;
            end
            default: begin
                w_port = PORT_CONTROL;
                w_data = control_byte;
            end
        endcase
    end

    always_comb begin
        act_next       = act_reg;
        cur_next       = cur_reg;
        sel_next       = sel_reg;
        out_valid_next = out_valid_reg;
        out_port_next  = out_port_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        if (load) begin
            sel_next = word_sel_t'(sel_reg + 1'b1);
        end
        if (finish) begin
            act_next = 1'b0;
        end
        if (pop) begin
            act_next = 1'b1;
            cur_next = q_dout;
            sel_next = W_CONTROL;
        end
        if (load) begin
            out_valid_next = 1'b1;
            out_port_next  = w_port;
            out_data_next  = w_data;
            out_last_next  = (sel_reg == W_COMMAND);
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg       <= 1'b0;
            sel_reg       <= W_CONTROL;
            out_valid_reg <= 1'b0;
        end else begin
            act_reg       <= act_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
        cur_reg      <= cur_next;
        out_port_reg <= out_port_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_data_reg, out_port_reg};
    assign m_tlast  = out_last_reg;

endmodule
`default_nettype wire

// ===== sv/lbac_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lbac_checker
    import lbac_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic                 m_tlast
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

    a_last_is_command: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[PORT_W-1:0] == PORT_COMMAND)
        else $error("last word does not go to the command port");

    a_run_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast
        |=> !m_tvalid || m_tdata[PORT_W-1:0] == PORT_CONTROL)
        else $error("new run does not open with the control port");

    a_control_then_precomp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tdata[PORT_W-1:0] == PORT_CONTROL
        |=> !m_tvalid || m_tdata[PORT_W-1:0] == PORT_PRECOMP)
        else $error("control word not followed by precomp word");

endmodule

bind lba_to_chs_command_issuer lbac_checker u_lbac_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
`default_nettype wire
